// ----- hdl/rdsc_pkg.sv -----
// rdsc_pkg: shared types and constants of the radix digit string converter
`default_nettype none

package rdsc_pkg;

    // digit buffer geometry
    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;

    // digit, radix and character widths
    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 64;

    // bits of dividend consumed by the divider per cycle
    localparam int CHUNK_W   = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_EMIT
    } rdsc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic advance;
    } rdsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic chunk_last;
        logic quot_zero;
        logic count_full;
        logic emit_last;
    } rdsc_status_t;

endpackage

`default_nettype wire

// ----- hdl/rdsc_ram.sv -----
// rdsc_ram: generic simple dual port ram with registered read
`default_nettype none

module rdsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/rdsc_datapath.sv -----
// rdsc_datapath: byte-wise divider, digit buffer and character mapping
`default_nettype none

module rdsc_datapath
    import rdsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rdsc_cmd_t            cmd,
    output rdsc_status_t              sts,
    input  wire logic [WORD_W-1:0]    value,
    input  wire logic [RADIX_W-1:0]   radix,
    input  wire logic [WORD_W-1:0]    chars_low,
    input  wire logic [WORD_W-1:0]    chars_high,
    output logic      [CHAR_W-1:0]    digit_char
);

    localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [PAD_W-1:0]   w_reg, w_next;
    logic [CIDX_W-1:0]  idx_reg, idx_next;
    logic [CIDX_W-1:0]  start_reg, start_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic               topq_zero_reg, topq_zero_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  emit_ptr_reg, emit_ptr_next;

    logic [PAD_W-1:0]   load_w;
    logic [CIDX_W-1:0]  load_top;
    logic [CHUNK_W-1:0] chunk_in;
    logic [CHUNK_W-1:0] q_chunk;
    logic [DIGIT_W-1:0] rem_out;
    logic               q_zero;
    logic               dec_start;
    logic               ram_we;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [WORD_W-1:0]  char_word;

    // masked input value and its highest nonzero byte
    always_comb begin
        load_w   = PAD_W'(value[VALUE_WIDTH-1:0]);
        load_top = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            if (load_w[i*CHUNK_W +: CHUNK_W] != '0) begin
                load_top = CIDX_W'(i);
            end
        end
    end

    // one byte of restoring division by the radix
    always_comb begin
        logic [RADIX_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        chunk_in = w_reg[idx_reg*CHUNK_W +: CHUNK_W];
        q_chunk  = '0;
        r        = rem_reg;
        for (int b = CHUNK_W - 1; b >= 0; b--) begin
            t = {r, chunk_in[b]};
            if (t >= radix) begin
                q_chunk[b] = 1'b1;
                t          = t - radix;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_out = r;
        q_zero  = (q_chunk == '0);
    end

    // quotient loses at most one leading byte per digit
    assign dec_start = (idx_reg == start_reg) ? q_zero : topq_zero_reg;
    assign start_next = (cmd.step && sts.chunk_last && dec_start && start_reg != '0)
                      ? start_reg - CIDX_W'(1)
                      : (cmd.load ? load_top : start_reg);

    assign sts.chunk_last = (idx_reg == '0);
    assign sts.quot_zero  = sts.chunk_last && (start_reg == '0) && q_zero;
    assign sts.count_full = (count_reg == CNT_W'(BUF_DEPTH - 1));
    assign sts.emit_last  = (emit_ptr_reg == '0);

    assign ram_we = cmd.step && sts.chunk_last;

    // next state of the division and emission registers
    always_comb begin
        w_next         = w_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        topq_zero_next = topq_zero_reg;
        count_next     = count_reg;
        emit_ptr_next  = emit_ptr_reg;
        if (cmd.load) begin
            w_next     = load_w;
            idx_next   = load_top;
            rem_next   = '0;
            count_next = '0;
        end else if (cmd.step) begin
            w_next[idx_reg*CHUNK_W +: CHUNK_W] = q_chunk;
            if (idx_reg == start_reg) begin
                topq_zero_next = q_zero;
            end
            if (sts.chunk_last) begin
                idx_next      = start_next;
                rem_next      = '0;
                count_next    = count_reg + CNT_W'(1);
                emit_ptr_next = count_reg[ADDR_W-1:0];
            end else begin
                idx_next = idx_reg - CIDX_W'(1);
                rem_next = rem_out;
            end
        end else if (cmd.advance) begin
            emit_ptr_next = emit_ptr_reg - ADDR_W'(1);
        end
    end

    // digit count is control state, the rest is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        w_reg         <= w_next;
        idx_reg       <= idx_next;
        start_reg     <= start_next;
        rem_reg       <= rem_next;
        topq_zero_reg <= topq_zero_next;
        emit_ptr_reg  <= emit_ptr_next;
    end

    // digit buffer, remainders least significant first
    rdsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (BUF_DEPTH)
    ) u_digit_buffer (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_out),
        .raddr (emit_ptr_next),
        .rdata (ram_rdata)
    );

    // digit to character through the alphabet registers
    assign char_word  = ram_rdata[DIGIT_W-1] ? chars_high : chars_low;
    assign digit_char = char_word[ram_rdata[DIGIT_W-2:0]*CHAR_W +: CHAR_W];

endmodule

`default_nettype wire

// ----- hdl/rdsc_ctrl.sv -----
// rdsc_ctrl: sequencing of load, division and character emission
`default_nettype none

module rdsc_ctrl
    import rdsc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_last,
    output rdsc_cmd_t         cmd,
    input  wire rdsc_status_t sts
);

    rdsc_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        m_last      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (sts.chunk_last && (sts.quot_zero || sts.count_full)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid     = 1'b1;
                m_last      = sts.emit_last;
                cmd.advance = m_ready && !sts.emit_last;
                if (m_ready && sts.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/radix_digit_string_converter.sv -----
// radix_digit_string_converter: top level with configuration registers
//
// Renders an unsigned value as digit characters in a base of 2 to MAX_RADIX,
// most significant first, with m_last on the final character; zero gives
// the single digit 0 character. Digits come from a shared divider that
// consumes one byte of the running quotient per cycle, starting at its
// highest nonzero byte. A value is accepted, divided digit by digit, the
// first digit is read from the buffer, and the characters then go out one
// per cycle while m_ready is high.
// One value is handled at a time; s_ready is high only between values and
// out of reset. Configuration writes are taken whenever the block is out
// of reset and must be made while no value is in progress.
`default_nettype none

module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_RADIX   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_W-1:0]    s_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [CHAR_W-1:0]    m_digit_char,
    output logic                      m_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

    logic [RADIX_W-1:0] radix_reg;
    logic [WORD_W-1:0]  chars_low_reg;
    logic [WORD_W-1:0]  chars_high_reg;
    logic [RADIX_W-1:0] radix_eff;
    rdsc_cmd_t          cmd;
    rdsc_status_t       sts;

    assign cfg_ready = aresetn;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= RADIX_RESET;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                REG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                REG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp the radix into the supported range
    always_comb begin
        priority if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    rdsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .sts     (sts)
    );

    rdsc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .value      (s_value),
        .radix      (radix_eff),
        .chars_low  (chars_low_reg),
        .chars_high (chars_high_reg),
        .digit_char (m_digit_char)
    );

endmodule

`default_nettype wire

// ----- verif/rdsc_char_checker.sv -----
// rdsc_char_checker: predicts and checks the character stream of the radix converter
`timescale 1ns / 1ps

module rdsc_char_checker
    import rdsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_RADIX   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [WORD_W-1:0]    s_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [CHAR_W-1:0]    m_digit_char,
    input  wire logic                 m_last,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    output int                        fail_count,
    output int                        chars_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_item_t;

    // characters still owed by the block, oldest first
    char_item_t expected_chars[$];

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] radix_shadow;
    logic [WORD_W-1:0]  alphabet_low;
    logic [WORD_W-1:0]  alphabet_high;
    int                 errors;

    // alphabet lookup: digits 8..15 live in the high word
    function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
        logic [WORD_W-1:0] word;
        word = d[3] ? alphabet_high : alphabet_low;
        return word[d[2:0]*CHAR_W +: CHAR_W];
    endfunction

    // repeated division, digits collected most significant first
    task automatic render_value(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0]  quot;
        logic [WORD_W-1:0]  base;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] digits[$];
        char_item_t         item;
        int                 k;
        if (radix_shadow < RADIX_MIN)
            base = WORD_W'(RADIX_MIN);
        else if (radix_shadow > MAX_RADIX)
            base = WORD_W'(MAX_RADIX);
        else
            base = WORD_W'(radix_shadow);
        quot = value;
        if (VALUE_WIDTH < WORD_W)
            quot = value & ((64'd1 << VALUE_WIDTH) - 64'd1);
        do begin
            digit = DIGIT_W'(quot % base);
            digits.push_front(digit);
            quot = quot / base;
        end while (quot != 0 && digits.size() < BUF_DEPTH);
        for (k = 0; k < digits.size(); k++) begin
            item.ch   = digit_char_of(digits[k]);
            item.last = (k == digits.size() - 1);
            expected_chars.push_back(item);
        end
    endtask

    // track configuration, predict on input items, compare on output items
    always @(posedge aclk) begin
        char_item_t want;
        if (!aresetn) begin
            expected_chars.delete();
            radix_shadow  = RADIX_RESET;
            alphabet_low  = '0;
            alphabet_high = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIX:      radix_shadow  = cfg_data[RADIX_W-1:0];
                    REG_CHARS_LOW:  alphabet_low  = cfg_data;
                    REG_CHARS_HIGH: alphabet_high = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                render_value(s_value);
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("digit_char %0h (last %0b) arrived with no item expected",
                           m_digit_char, m_last);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_digit_char !== want.ch) begin
                        $error("digit_char mismatch: expected %0h actual %0h",
                               want.ch, m_digit_char);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last mismatch: expected %0b actual %0b", want.last, m_last);
                        errors++;
                    end
                end
            end
        end
        fail_count    <= errors;
        chars_pending <= expected_chars.size();
    end

endmodule

// ----- verif/tb.sv -----
// tb: stimulus, flow control and verdict for the radix digit string converter
`timescale 1ns / 1ps

module tb
    import rdsc_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEMS_PER_SETTING = 66;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [WORD_W-1:0] ASCII_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [WORD_W-1:0] ASCII_HIGH = 64'h6665_6463_6261_3938;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_value   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [CHAR_W-1:0]    m_digit_char;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    int fail_count;
    int chars_pending;
    int cycle_count     = 0;
    int send_idle_pct   = 25;
    int recv_idle_pct   = 58;

    radix_digit_string_converter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rdsc_char_checker char_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_char  (m_digit_char),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mix of magnitudes so every digit count shows up
    function automatic logic [WORD_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(63);
            3:       return WORD_W'($urandom_range(255));
            default: return rand_word() >> $urandom_range(63);
        endcase
    endfunction

    // one item on the input channel, valid held until taken
    task automatic send_value(input logic [WORD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off the sender until every character is out and the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0 || !s_ready);
    endtask

    // one register write, valid left high for a following write
    task automatic post_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // full register set; radix write carries random upper bits
    task automatic program_regs(input logic [RADIX_W-1:0] radix,
                                input logic [WORD_W-1:0] chars_low,
                                input logic [WORD_W-1:0] chars_high,
                                input bit poke_unused);
        logic [WORD_W-1:0] radix_word;
        radix_word = rand_word();
        radix_word[RADIX_W-1:0] = radix;
        if (poke_unused)
            post_reg(REG_UNUSED, rand_word());
        post_reg(REG_RADIX, radix_word);
        post_reg(REG_CHARS_LOW, chars_low);
        post_reg(REG_CHARS_HIGH, chars_high);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int setting;
        int n;
        logic [RADIX_W-1:0] radix;
        logic [WORD_W-1:0]  chars_low;
        logic [WORD_W-1:0]  chars_high;

        // reset
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset configuration
        send_value('0);
        send_value(64'd12345);
        drain();

        // directed: decimal with a readable alphabet, boundaries around the radix
        program_regs(5'd10, ASCII_LOW, ASCII_HIGH, 1'b1);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value('1);
        send_value(64'd1 << 63);
        drain();

        // radix below two acts as binary
        program_regs(5'd0, rand_word(), rand_word(), 1'b0);
        send_value('1);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'd1 << 63);
        drain();
        program_regs(5'd1, rand_word(), rand_word(), 1'b0);
        send_value(64'd3);
        drain();

        // radix above the limit acts as hex
        program_regs(5'd31, rand_word(), rand_word(), 1'b0);
        send_value('1);
        send_value(64'd15);
        send_value(64'd16);
        drain();
        program_regs(5'd17, ASCII_LOW, ASCII_HIGH, 1'b0);
        send_value(64'd255);
        drain();

        // digits one to fifteen, extreme alphabets
        program_regs(5'd16, '1, '0, 1'b0);
        send_value(64'h0123_4567_89ab_cdef);
        drain();
        program_regs(5'd3, rand_word(), rand_word(), 1'b0);
        send_value('1);

        // random part: six settings across the three flow-control modes
        for (setting = 0; setting < 6; setting++) begin
            if (setting == 2) begin
                send_idle_pct = 58;
                recv_idle_pct = 25;
            end else if (setting == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            chars_low  = rand_word();
            chars_high = rand_word();
            case (setting)
                0: radix = 5'd2;
                1: begin
                    radix     = 5'd16;
                    chars_low = '1;
                end
                2: begin
                    radix      = 5'd10;
                    chars_low  = ASCII_LOW;
                    chars_high = ASCII_HIGH;
                end
                3: radix = 5'd31;
                4: begin
                    radix      = RADIX_W'($urandom_range(15, 3));
                    chars_high = '1;
                end
                default: radix = RADIX_W'($urandom_range(31));
            endcase
            drain();
            program_regs(radix, chars_low, chars_high, 1'b0);
            for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                send_value(rand_value());
                if ($urandom_range(39) == 0)
                    drain();
            end
        end

        // let the last characters out, then allow for trailing activity
        drain();
        repeat (150) @(posedge aclk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
